>>> rtl/core/dmig_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmig_pkg
// Shared types and constants of the disk mesh index generator.
// ----------------------------------------------------------------------------
package dmig_pkg;

  localparam int unsigned MaxRings    = 4096;
  localparam int unsigned MaxSegments = 4096;

  localparam int unsigned CfgW = 13;  // configuration register width
  localparam int unsigned PosW = 12;  // ring and segment position width
  localparam int unsigned IdxW = 25;  // vertex index width

  localparam logic [CfgW-1:0] RingCountReset    = CfgW'(2);
  localparam logic [CfgW-1:0] SegmentCountReset = CfgW'(3);
  localparam logic [CfgW-1:0] MinRings          = CfgW'(2);
  localparam logic [CfgW-1:0] MinSegments       = CfgW'(3);

  typedef enum logic [0:0] {
    REG_RING_COUNT    = 1'b0,
    REG_SEGMENT_COUNT = 1'b1
  } dmig_reg_e;

  // traversal position
  typedef struct packed {
    logic            in_annulus;
    logic [PosW-1:0] ring_pos;
    logic [PosW-1:0] seg_pos;
    logic            second_half;
  } dmig_state_t;

  // effective geometry after saturation
  typedef struct packed {
    logic [CfgW-1:0] rings;
    logic [CfgW-1:0] segs;
  } dmig_geom_t;

  typedef struct packed {
    logic [IdxW-1:0] first_index;
    logic [IdxW-1:0] second_index;
    logic [IdxW-1:0] third_index;
    logic            last_triangle;
    logic            config_error;
  } dmig_tri_t;

  localparam dmig_state_t StartState = '{
    in_annulus:  1'b0,
    ring_pos:    '0,
    seg_pos:     '0,
    second_half: 1'b0
  };

endpackage

>>> rtl/core/dmig_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmig_cfg
// Ring and segment count registers with saturation to the mesh limits.
// ----------------------------------------------------------------------------
module dmig_cfg import dmig_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  dmig_reg_e       cfg_index_i,
  input  logic [CfgW-1:0] cfg_data_i,
  output dmig_geom_t      geom_o
);

  localparam logic [CfgW-1:0] RingLimit = CfgW'(MaxRings);
  localparam logic [CfgW-1:0] SegLimit  = CfgW'(MaxSegments);

  logic [CfgW-1:0] ring_count_q;
  logic [CfgW-1:0] segment_count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_count_q    <= RingCountReset;
      segment_count_q <= SegmentCountReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_RING_COUNT:    ring_count_q    <= cfg_data_i;
        REG_SEGMENT_COUNT: segment_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    geom_o.rings = (ring_count_q > RingLimit) ? RingLimit : ring_count_q;
    geom_o.segs  = (segment_count_q > SegLimit) ? SegLimit : segment_count_q;
  end

endmodule

>>> rtl/core/dmig_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmig_step
// Triangle indices and next traversal position for one request.
// ----------------------------------------------------------------------------
module dmig_step import dmig_pkg::*; (
  input  dmig_state_t state_i,
  input  dmig_geom_t  geom_i,
  input  logic        restart_i,
  output dmig_state_t state_o,
  output dmig_tri_t   tri_o
);

  dmig_state_t     st_restart;
  dmig_state_t     st;
  logic            geom_err;
  logic            out_of_range;
  logic [CfgW-1:0] s_inc;
  logic            last_seg;
  logic [PosW-1:0] nxt;
  logic [PosW-1:0] r;
  logic [PosW-1:0] s;
  logic [IdxW-1:0] prod;
  logic [IdxW-1:0] base_r;
  logic [IdxW-1:0] base_r1;
  logic            last_ring;

  always_comb begin
    st_restart = restart_i ? StartState : state_i;
    geom_err   = (geom_i.rings < MinRings) || (geom_i.segs < MinSegments);
    // drop a position that no longer fits the geometry
    out_of_range = ({1'b0, st_restart.seg_pos} >= geom_i.segs) ||
                   (st_restart.in_annulus &&
                    (CfgW'(st_restart.ring_pos) + CfgW'(1) >= geom_i.rings));
    st = out_of_range ? StartState : st_restart;

    s        = st.seg_pos;
    r        = st.ring_pos;
    s_inc    = CfgW'(s) + CfgW'(1);
    last_seg = (s_inc == geom_i.segs);
    nxt      = last_seg ? '0 : s_inc[PosW-1:0];

    prod    = IdxW'(r) * IdxW'(geom_i.segs);
    base_r  = prod + IdxW'(1);
    base_r1 = base_r + IdxW'(geom_i.segs);

    last_ring = ((CfgW+1)'(r) + (CfgW+1)'(2)) >= (CfgW+1)'(geom_i.rings);
  end

  always_comb begin
    state_o = st;
    tri_o   = '0;
    if (geom_err) begin
      state_o             = StartState;
      tri_o.config_error  = 1'b1;
    end else if (!st.in_annulus) begin
      // centre fan
      tri_o.first_index  = '0;
      tri_o.second_index = IdxW'(s) + IdxW'(1);
      tri_o.third_index  = IdxW'(nxt) + IdxW'(1);
      if (last_seg) begin
        state_o            = StartState;
        state_o.in_annulus = 1'b1;
      end else begin
        state_o.seg_pos = s_inc[PosW-1:0];
      end
    end else if (!st.second_half) begin
      tri_o.first_index   = base_r + IdxW'(s);
      tri_o.second_index  = base_r1 + IdxW'(s);
      tri_o.third_index   = base_r + IdxW'(nxt);
      state_o.second_half = 1'b1;
    end else begin
      tri_o.first_index   = base_r + IdxW'(nxt);
      tri_o.second_index  = base_r1 + IdxW'(s);
      tri_o.third_index   = base_r1 + IdxW'(nxt);
      state_o.second_half = 1'b0;
      if (last_seg) begin
        state_o.seg_pos = '0;
        if (last_ring) begin
          tri_o.last_triangle = 1'b1;
          state_o             = StartState;
        end else begin
          state_o.ring_pos = PosW'(CfgW'(r) + CfgW'(1));
        end
      end else begin
        state_o.seg_pos = s_inc[PosW-1:0];
      end
    end
  end

endmodule

>>> rtl/core/disk_mesh_index_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disk_mesh_index_generator_unit
// Emits the triangle index list of a disk mesh, one triangle per request.
// ----------------------------------------------------------------------------
// Each accepted request yields one triangle in the output register the cycle
// after; while in_stall_o is low a request can be accepted every cycle.
// The traversal position updates at acceptance; out_stall_i may hold the register
// while the next request still enters once that register drains. The cycle
// time is set by the position check, the ring-times-segments multiply and the
// index adders feeding the output register. Triangles run through the centre
// fan first, then two per sector for each ring pair; restart_i jumps back to
// the first fan triangle. Ring count below 2 or segment count below 3 gives a
// result with config_error set and zero indices.
module disk_mesh_index_generator_unit import dmig_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  dmig_reg_e       cfg_index_i,
  input  logic [CfgW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            restart_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [IdxW-1:0] first_index_o,
  output logic [IdxW-1:0] second_index_o,
  output logic [IdxW-1:0] third_index_o,
  output logic            last_triangle_o,
  output logic            config_error_o
);

  dmig_geom_t  geom;
  dmig_state_t state_q;
  dmig_state_t state_d;
  dmig_tri_t   tri_d;
  dmig_tri_t   tri_q;
  logic        out_valid_q;
  logic        accept;

  dmig_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .geom_o      (geom)
  );

  dmig_step u_step (
    .state_i   (state_q),
    .geom_i    (geom),
    .restart_i (restart_i),
    .state_o   (state_d),
    .tri_o     (tri_d)
  );

  // take a new item whenever the output register is empty or draining
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StartState;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q <= state_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tri_q <= tri_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign first_index_o   = tri_q.first_index;
  assign second_index_o  = tri_q.second_index;
  assign third_index_o   = tri_q.third_index;
  assign last_triangle_o = tri_q.last_triangle;
  assign config_error_o  = tri_q.config_error;

endmodule
